// File: hw/rtl/ahk_pkg.sv
package ahk_pkg;

  localparam int MAX_CHARS_DEF = 14;

  // HID usage codes
  localparam logic [7:0] KEY_ZERO   = 8'd39;
  localparam logic [7:0] KEY_ONE    = 8'd30;
  localparam logic [7:0] KEY_A      = 8'd4;
  localparam logic [7:0] KEY_PERIOD = 8'h37;
  localparam logic [7:0] KEY_MINUS  = 8'h2D;
  localparam logic [7:0] KEY_SPACE  = 8'h2C;
  localparam logic [7:0] KEY_TAB    = 8'h2B;
  localparam logic [7:0] KEY_ENTER  = 8'h28;
  localparam logic [7:0] KEY_NONE   = 8'h00;

  localparam logic [7:0] MOD_LSHIFT = 8'h02;
  localparam logic [7:0] MOD_NONE   = 8'h00;

  // ASCII
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  typedef struct packed {
    logic       start_message;
    logic [7:0] character;
    logic       caps_on;
  } char_t;

  typedef struct packed {
    logic [7:0] modifier;
    logic [7:0] keycode;
    logic       sending;
    logic       last;
  } report_t;

  // One decoded character on its way to the output stage
  typedef struct packed {
    logic [7:0] modifier;
    logic [7:0] keycode;
    logic       sending;
    logic       pair;     // press followed by release
  } entry_t;

endpackage

// File: hw/rtl/ahk_map.sv
module ahk_map (
  input  logic [7:0] character,
  input  logic       caps_on,
  output logic [7:0] modifier,
  output logic [7:0] keycode
);
  import ahk_pkg::*;

  always_comb begin
    modifier = MOD_NONE;
    keycode  = KEY_NONE;
    if (character == CH_ZERO) begin
      keycode = KEY_ZERO;
    end else if (character inside {[CH_ONE:CH_NINE]}) begin
      keycode = KEY_ONE + (character - CH_ONE);
    end else if (character inside {[CH_LO_A:CH_LO_Z]}) begin
      modifier = caps_on ? MOD_LSHIFT : MOD_NONE;
      keycode  = KEY_A + (character - CH_LO_A);
    end else if (character inside {[CH_UP_A:CH_UP_Z]}) begin
      modifier = caps_on ? MOD_NONE : MOD_LSHIFT;
      keycode  = KEY_A + (character - CH_UP_A);
    end else begin
      case (character)
        CH_PERIOD: keycode = KEY_PERIOD;
        CH_UNDER: begin
          modifier = MOD_LSHIFT;
          keycode  = KEY_MINUS;
        end
        CH_MINUS: keycode = KEY_MINUS;
        CH_SPACE: keycode = KEY_SPACE;
        CH_TAB:   keycode = KEY_TAB;
        CH_LF:    keycode = KEY_ENTER;
        default:  keycode = KEY_NONE;
      endcase
    end
  end

endmodule

// File: hw/rtl/ahk_out.sv
module ahk_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ahk_pkg::entry_t   entry,
  output logic              free,
  output logic              report_valid,
  input  logic              report_stall,
  output ahk_pkg::report_t  report_data
);
  import ahk_pkg::*;

  logic   valid;
  logic   release_phase;
  entry_t held;
  logic   final_word;

  assign final_word   = release_phase || !held.pair;
  assign free         = !valid || (!report_stall && final_word);
  assign report_valid = valid;

  always_comb begin
    if (release_phase) begin
      report_data = '{modifier: MOD_NONE, keycode: KEY_NONE, sending: 1'b1, last: 1'b1};
    end else begin
      report_data = '{modifier: held.modifier, keycode: held.keycode,
                      sending: held.sending, last: !held.pair};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      release_phase <= 1'b0;
    end else if (free) begin
      valid         <= load;
      release_phase <= 1'b0;
    end else if (!report_stall) begin
      // press taken, release comes next
      release_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= entry;
    end
  end

  a_release_follows: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_stall && !report_data.last |=>
      report_valid && report_data.last && report_data.sending &&
      report_data.keycode == KEY_NONE)
    else $error("press not followed by release");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_data.sending |->
      report_data.last && report_data.keycode == KEY_NONE &&
      report_data.modifier == MOD_NONE)
    else $error("not-sending word carries a key");

  a_release_has_word: assert property (@(posedge clk) disable iff (rst)
    release_phase |-> valid && held.pair)
    else $error("release phase without a pending pair");

endmodule

// File: hw/rtl/ascii_to_hid_key_reports_core.sv
// ASCII to HID keyboard report converter.
//
// Input channel char_valid / char_stall / char_data carries one character word
// with its start-of-message mark and the host caps-lock state. Output channel
// report_valid / report_stall / report_data carries HID report words.
// While a message is active, each character gives two words: the key press
// (modifier and keycode, last = 0) then the release (no key, last = 1).
// A NUL, an idle block, or the word after MAX_CHARS characters ends the
// message; that word and every later one give a single empty word with
// sending = 0 and last = 1, until start_message opens a new message.
//
// Path: a character word is registered in the input register, decoded, and
// loaded into the output register once that register is free; its first
// report is shown from the output register.
// Throughput: the output register emits one report word per cycle unless
// report_stall holds it, and loads the next word as the last one is taken.
// An input register in front takes a word while a report waits to be taken.
// Reset clears the message state and empties both registers. When the
// receiver stalls, the shown word holds and char_stall rises once the input
// register is full.
module ascii_to_hid_key_reports_core #(
  parameter int MAX_CHARS = ahk_pkg::MAX_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_stall,
  input  ahk_pkg::char_t    char_data,
  output logic              report_valid,
  input  logic              report_stall,
  output ahk_pkg::report_t  report_data
);
  import ahk_pkg::*;

  localparam int CW = $clog2(MAX_CHARS + 1);
  localparam logic [CW-1:0] LIMIT = CW'(MAX_CHARS);

  logic          held_valid;
  char_t         held;
  logic          message_active;
  logic [CW-1:0] char_count;

  logic          free;
  logic          move;
  logic          active_eff;
  logic [CW-1:0] count_eff;
  logic          done;
  logic [7:0]    map_mod;
  logic [7:0]    map_key;
  entry_t        entry;

  assign char_stall = held_valid && !free;
  assign move       = held_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!char_stall) begin
      held_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      held <= char_data;
    end
  end

  ahk_map u_map (
    .character (held.character),
    .caps_on   (held.caps_on),
    .modifier  (map_mod),
    .keycode   (map_key)
  );

  always_comb begin
    active_eff = held.start_message || message_active;
    count_eff  = held.start_message ? '0 : char_count;
    done       = !active_eff || (count_eff >= LIMIT) || (held.character == CH_NUL);
    entry.modifier = done ? MOD_NONE : map_mod;
    entry.keycode  = done ? KEY_NONE : map_key;
    entry.sending  = !done;
    entry.pair     = !done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_active <= 1'b0;
      char_count     <= '0;
    end else if (move) begin
      message_active <= !done;
      char_count     <= done ? count_eff : count_eff + 1'b1;
    end
  end

  ahk_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (move),
    .entry        (entry),
    .free         (free),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report_data  (report_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    char_count <= LIMIT)
    else $error("character count beyond limit");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    held_valid && !free |=> held_valid && $stable(held))
    else $error("input register lost a word");

  a_ended_stays_closed: assert property (@(posedge clk) disable iff (rst)
    move && done |=> !message_active)
    else $error("message still open after it ended");

endmodule
